[src/bti_pkg.sv]
// ----------------------------------------------------------------------------
// Bilinear table interpolator package
// Shared sizes, codes and the command and status records that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bti_pkg;

  localparam int MAX_X_POINTS = 32;
  localparam int MAX_Y_POINTS = 32;
  localparam int Z_DEPTH      = MAX_X_POINTS * MAX_Y_POINTS;

  localparam int XAW    = $clog2(MAX_X_POINTS);
  localparam int YAW    = $clog2(MAX_Y_POINTS);
  localparam int ZAW    = $clog2(Z_DEPTH);
  localparam int SCAN_N = (MAX_X_POINTS > MAX_Y_POINTS) ? MAX_X_POINTS : MAX_Y_POINTS;
  localparam int KW     = $clog2(SCAN_N + 1);

  localparam int SZW      = 6;
  localparam int IDXW     = 10;
  localparam int WORDW    = 16;
  localparam int QW       = 24;
  localparam int ZW       = 24;
  localparam int CFG_IDXW = 2;

  // Multiplier operands: offset along an axis and a difference of table values.
  localparam int MA_W  = QW + 1;
  localparam int MB_W  = 33;
  localparam int PW    = MA_W + MB_W;
  localparam int DEN_W = 25;
  localparam int NUM_W = 60;
  localparam int DIV_STEPS = NUM_W / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);
  localparam int QUO_W     = NUM_W + 1;
  localparam int ROW_W     = 32;

  localparam logic [CFG_IDXW-1:0] REG_X_POINTS = CFG_IDXW'(0);
  localparam logic [CFG_IDXW-1:0] REG_Y_POINTS = CFG_IDXW'(1);

  typedef enum logic [1:0] {
    CMD_WR_X  = 2'd0,
    CMD_WR_Y  = 2'd1,
    CMD_WR_Z  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PASS_ROW0 = 2'd0,
    PASS_ROW1 = 2'd1,
    PASS_COL  = 2'd2
  } pass_e;

  typedef struct packed {
    logic  accept;
    logic  scan_clr;
    logic  scan_en;
    logic  base_en;
    logic  zrd_en;
    logic  mul_en;
    logic  div_start;
    logic  acc_en;
    logic  err_set;
    pass_e pass;
  } dp_cmd_t;

  typedef struct packed {
    logic size_bad;
    logic row_bad;
    logic scan_done;
    logic zrd_done;
    logic div_busy;
  } dp_sts_t;

endpackage

[src/bti_div.sv]
// ----------------------------------------------------------------------------
// Rounding divider
// Signed dividend over a positive divisor, rounded to nearest with ties away
// from zero; restoring division, two quotient bits a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bti_div import bti_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [PW-1:0]    num_i,
  input  logic        [DEN_W-1:0] den_i,
  output logic                    busy_o,
  output logic signed [QUO_W-1:0] quo_o
);

  logic              run_q;
  logic [STEP_W-1:0] cnt_q;
  logic [NUM_W-1:0]  sh_q;
  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W-1:0]  den_q;
  logic              neg_q;

  logic [PW-1:0]    mag;
  logic [NUM_W-1:0] num_adj;
  logic [DEN_W:0]   t1, t2, d1, d2;
  logic             ge1, ge2;
  logic [DEN_W-1:0] r1, r2;

  always_comb begin
    mag     = num_i[PW-1] ? PW'(-num_i) : PW'(num_i);
    num_adj = NUM_W'(mag) + NUM_W'(den_i >> 1);
    t1  = {rem_q, sh_q[NUM_W-1]};
    d1  = t1 - {1'b0, den_q};
    ge1 = (t1 >= {1'b0, den_q});
    r1  = ge1 ? d1[DEN_W-1:0] : t1[DEN_W-1:0];
    t2  = {r1, sh_q[NUM_W-2]};
    d2  = t2 - {1'b0, den_q};
    ge2 = (t2 >= {1'b0, den_q});
    r2  = ge2 ? d2[DEN_W-1:0] : t2[DEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= STEP_W'(DIV_STEPS);
    end else if (run_q) begin
      cnt_q <= cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= num_adj;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[PW-1];
    end else if (run_q) begin
      sh_q  <= {sh_q[NUM_W-3:0], ge1, ge2};
      rem_q <= r2;
    end
  end

  assign busy_o = run_q;
  assign quo_o  = neg_q ? -$signed({1'b0, sh_q}) : $signed({1'b0, sh_q});

endmodule

[src/bti_datapath.sv]
// ----------------------------------------------------------------------------
// Bilinear table interpolator datapath
// Table memories, size registers, breakpoint scan, grid fetch, multiplier,
// divider and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bti_datapath import bti_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dp_cmd_t                   cmd_i,
  output dp_sts_t                   sts_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDXW-1:0]       cfg_index_i,
  input  logic [SZW-1:0]            cfg_data_i,
  input  logic [1:0]                command_i,
  input  logic [IDXW-1:0]           entry_index_i,
  input  logic signed [WORDW-1:0]   entry_value_i,
  input  logic signed [QW-1:0]      query_x_i,
  input  logic signed [QW-1:0]      query_y_i,
  output logic signed [ZW-1:0]      z_value_o,
  output logic                      table_error_o
);

  localparam int SW  = QUO_W + 1;
  localparam int BMW = ZAW + SZW + 1;

  function automatic logic signed [ROW_W-1:0] sat_row(input logic signed [SW-1:0] v);
    logic [SW-ROW_W:0] top;
    top = v[SW-1:ROW_W-1];
    if ((&top) || !(|top)) return v[ROW_W-1:0];
    else if (v[SW-1]) return {1'b1, {(ROW_W-1){1'b0}}};
    else return {1'b0, {(ROW_W-1){1'b1}}};
  endfunction

  function automatic logic signed [ZW-1:0] sat_out(input logic signed [SW-1:0] v);
    logic [SW-ZW:0] top;
    top = v[SW-1:ZW-1];
    if ((&top) || !(|top)) return v[ZW-1:0];
    else if (v[SW-1]) return {1'b1, {(ZW-1){1'b0}}};
    else return {1'b0, {(ZW-1){1'b1}}};
  endfunction

  logic signed [WORDW-1:0] x_mem [MAX_X_POINTS];
  logic signed [WORDW-1:0] y_mem [MAX_Y_POINTS];
  logic signed [WORDW-1:0] z_mem [Z_DEPTH];

  logic [SZW-1:0] xs_q, ys_q;
  logic signed [QW-1:0] qx_q, qy_q;

  logic [KW-1:0] k_q;
  logic [KW-1:0] p;
  logic [KW-1:0] scan_n;
  logic signed [WORDW-1:0] x_rd_q, y_rd_q;
  logic signed [WORDW-1:0] xlo_q, xhi_q, xprev_q, ylo_q, yhi_q, yprev_q;
  logic [XAW-1:0] ix_q;
  logic [YAW-1:0] iy_q;
  logic xbad_q, ybad_q;
  logic signed [QW-1:0] x_q8, y_q8;

  logic [ZAW-1:0] zbase_q, zaddr;
  logic [BMW-1:0] base_w;
  logic [2:0] zc_q;
  logic signed [WORDW-1:0] z_rd_q, zl0_q, zh0_q, zl1_q, zh1_q;

  logic signed [MA_W-1:0] dx_q, dy_q, ma;
  logic [DEN_W-1:0] dxw_q, dyw_q;
  logic signed [WORDW:0] xdiff, ydiff;
  logic signed [MB_W-1:0] mb;
  logic signed [PW-1:0] prod_q;
  logic signed [ROW_W-1:0] r1_q, r2_q;
  logic signed [QUO_W-1:0] quo;
  logic div_busy;
  logic signed [SW-1:0] row_sum, col_sum;
  logic signed [WORDW-1:0] zl_sel;

  logic signed [ZW-1:0] z_q;
  logic err_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xs_q <= SZW'(2);
      ys_q <= SZW'(2);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_X_POINTS: xs_q <= cfg_data_i;
        REG_Y_POINTS: ys_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Table memories: one write port on the accepted item, one registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && command_i == CMD_WR_X && entry_index_i < MAX_X_POINTS) begin
      x_mem[XAW'(entry_index_i)] <= entry_value_i;
    end
    x_rd_q <= x_mem[k_q[XAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && command_i == CMD_WR_Y && entry_index_i < MAX_Y_POINTS) begin
      y_mem[YAW'(entry_index_i)] <= entry_value_i;
    end
    y_rd_q <= y_mem[k_q[YAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && command_i == CMD_WR_Z && entry_index_i < Z_DEPTH) begin
      z_mem[ZAW'(entry_index_i)] <= entry_value_i;
    end
    z_rd_q <= z_mem[zaddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && command_i == CMD_QUERY) begin
      qx_q <= query_x_i;
      qy_q <= query_y_i;
    end
  end

  // Breakpoint scan: the word read for index k arrives in the next cycle.
  assign p      = k_q - KW'(1);
  assign scan_n = (xs_q > ys_q) ? KW'(xs_q) : KW'(ys_q);
  assign x_q8   = $signed({x_rd_q, 8'b0});
  assign y_q8   = $signed({y_rd_q, 8'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= '0;
      xbad_q <= 1'b0;
      ybad_q <= 1'b0;
    end else if (cmd_i.scan_clr) begin
      k_q    <= '0;
      xbad_q <= 1'b0;
      ybad_q <= 1'b0;
    end else if (cmd_i.scan_en) begin
      if (k_q != scan_n) begin
        k_q <= k_q + KW'(1);
      end
      if (k_q != '0 && p != '0 && p < KW'(xs_q) && xprev_q >= x_rd_q) begin
        xbad_q <= 1'b1;
      end
      if (k_q != '0 && p != '0 && p < KW'(ys_q) && yprev_q >= y_rd_q) begin
        ybad_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_en && k_q != '0) begin
      if (p < KW'(xs_q)) begin
        xprev_q <= x_rd_q;
        if (p == '0) begin
          xlo_q <= x_rd_q;
          ix_q  <= '0;
        end else begin
          if (p == KW'(ix_q) + KW'(1)) begin
            xhi_q <= x_rd_q;
          end
          if (p <= KW'(xs_q) - KW'(2) && qx_q >= x_q8) begin
            ix_q  <= p[XAW-1:0];
            xlo_q <= x_rd_q;
          end
        end
      end
      if (p < KW'(ys_q)) begin
        yprev_q <= y_rd_q;
        if (p == '0) begin
          ylo_q <= y_rd_q;
          iy_q  <= '0;
        end else begin
          if (p == KW'(iy_q) + KW'(1)) begin
            yhi_q <= y_rd_q;
          end
          if (p <= KW'(ys_q) - KW'(2) && qy_q >= y_q8) begin
            iy_q  <= p[YAW-1:0];
            ylo_q <= y_rd_q;
          end
        end
      end
    end
  end

  // Cell set-up: grid base address, offsets and breakpoint spans.
  assign base_w = BMW'(iy_q) * BMW'(xs_q) + BMW'(ix_q);
  assign xdiff  = $signed({xhi_q[WORDW-1], xhi_q}) - $signed({xlo_q[WORDW-1], xlo_q});
  assign ydiff  = $signed({yhi_q[WORDW-1], yhi_q}) - $signed({ylo_q[WORDW-1], ylo_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.base_en) begin
      zbase_q <= base_w[ZAW-1:0];
      dx_q    <= $signed({qx_q[QW-1], qx_q}) - $signed({xlo_q[WORDW-1], xlo_q, 8'b0});
      dy_q    <= $signed({qy_q[QW-1], qy_q}) - $signed({ylo_q[WORDW-1], ylo_q, 8'b0});
      dxw_q   <= DEN_W'(xdiff[WORDW-1:0]);
      dyw_q   <= {xdiff[WORDW] & 1'b0, ydiff[WORDW-1:0], 8'b0};
    end
  end

  // Grid fetch: the four corners, one read a cycle.
  always_comb begin
    case (zc_q[1:0])
      2'd0:    zaddr = zbase_q;
      2'd1:    zaddr = zbase_q + ZAW'(1);
      2'd2:    zaddr = zbase_q + ZAW'(xs_q);
      default: zaddr = zbase_q + ZAW'(xs_q) + ZAW'(1);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zc_q <= '0;
    end else if (cmd_i.base_en) begin
      zc_q <= '0;
    end else if (cmd_i.zrd_en && zc_q != 3'd4) begin
      zc_q <= zc_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.zrd_en) begin
      case (zc_q)
        3'd1:    zl0_q <= z_rd_q;
        3'd2:    zh0_q <= z_rd_q;
        3'd3:    zl1_q <= z_rd_q;
        3'd4:    zh1_q <= z_rd_q;
        default: ;
      endcase
    end
  end

  // Shared multiplier and divider.
  always_comb begin
    case (cmd_i.pass)
      PASS_ROW0: begin
        ma = dx_q;
        mb = MB_W'($signed({zh0_q[WORDW-1], zh0_q}) - $signed({zl0_q[WORDW-1], zl0_q}));
      end
      PASS_ROW1: begin
        ma = dx_q;
        mb = MB_W'($signed({zh1_q[WORDW-1], zh1_q}) - $signed({zl1_q[WORDW-1], zl1_q}));
      end
      default: begin
        ma = dy_q;
        mb = $signed({r2_q[ROW_W-1], r2_q}) - $signed({r1_q[ROW_W-1], r1_q});
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= ma * mb;
    end
  end

  bti_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (prod_q),
    .den_i   ((cmd_i.pass == PASS_COL) ? dyw_q : dxw_q),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  // Accumulate: row values, then the value between the rows.
  assign zl_sel  = (cmd_i.pass == PASS_ROW0) ? zl0_q : zl1_q;
  assign row_sum = SW'($signed({zl_sel, 8'b0})) + SW'(quo);
  assign col_sum = SW'(r1_q) + SW'(quo);

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en) begin
      case (cmd_i.pass)
        PASS_ROW0: r1_q <= sat_row(row_sum);
        PASS_ROW1: r2_q <= sat_row(row_sum);
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= 1'b0;
      z_q   <= '0;
    end else if (cmd_i.err_set) begin
      err_q <= 1'b1;
      z_q   <= '0;
    end else if (cmd_i.accept) begin
      err_q <= 1'b0;
    end else if (cmd_i.acc_en && cmd_i.pass == PASS_COL) begin
      z_q <= sat_out(col_sum);
    end
  end

  assign sts_o.size_bad  = (xs_q < SZW'(2)) || (ys_q < SZW'(2)) ||
                           (xs_q > MAX_X_POINTS) || (ys_q > MAX_Y_POINTS);
  assign sts_o.row_bad   = xbad_q | ybad_q;
  assign sts_o.scan_done = (k_q == scan_n);
  assign sts_o.zrd_done  = (zc_q == 3'd4);
  assign sts_o.div_busy  = div_busy;

  assign z_value_o     = z_q;
  assign table_error_o = err_q;

endmodule

[src/bti_ctrl.sv]
// ----------------------------------------------------------------------------
// Bilinear table interpolator controller
// Sequences one query through scan, grid fetch and three multiply and
// divide passes; table writes complete on acceptance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bti_ctrl import bti_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] command_i,
  output logic       busy,
  output logic       done_o,
  output dp_cmd_t    cmd_o,
  input  dp_sts_t    sts_i
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_CHECK = 10'b00_0000_0010,
    S_SCAN  = 10'b00_0000_0100,
    S_BASE  = 10'b00_0000_1000,
    S_ZRD   = 10'b00_0001_0000,
    S_MUL   = 10'b00_0010_0000,
    S_DIVS  = 10'b00_0100_0000,
    S_DIVW  = 10'b00_1000_0000,
    S_ACC   = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  pass_e  pass_q, pass_d;

  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    cmd_o   = '0;
    cmd_o.pass = pass_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.accept = start;
        if (start && command_i == CMD_QUERY) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.scan_clr = 1'b1;
        pass_d = PASS_ROW0;
        if (sts_i.size_bad) begin
          cmd_o.err_set = 1'b1;
          state_d = S_OUT;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_BASE;
        end
      end
      S_BASE: begin
        cmd_o.base_en = 1'b1;
        if (sts_i.row_bad) begin
          cmd_o.err_set = 1'b1;
          state_d = S_OUT;
        end else begin
          state_d = S_ZRD;
        end
      end
      S_ZRD: begin
        cmd_o.zrd_en = 1'b1;
        if (sts_i.zrd_done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d = S_DIVS;
      end
      S_DIVS: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIVW;
      end
      S_DIVW: begin
        if (!sts_i.div_busy) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.acc_en = 1'b1;
        case (pass_q)
          PASS_ROW0: begin
            pass_d  = PASS_ROW1;
            state_d = S_MUL;
          end
          PASS_ROW1: begin
            pass_d  = PASS_COL;
            state_d = S_MUL;
          end
          default: state_d = S_OUT;
        endcase
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass_q  <= PASS_ROW0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_OUT);

endmodule

[src/bilinear_table_interpolator_unit.sv]
// ----------------------------------------------------------------------------
// Bilinear table interpolator
// Two-dimensional lookup table with linear interpolation and extrapolation
// in Q16.8, built as a controller and a datapath.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Word
//   item      in         start high, busy low   command, entry_index, entry_value,
//                                               query_x, query_y
//   result    out        done_o strobe          z_value, table_error
//   config    in         cfg_valid_i, cfg_ready_o  cfg_index_i, cfg_data_i
//
// A table write (commands 0 to 2) is stored at the edge that accepts it and
// busy stays low, so a new word can follow in the next cycle.
// A query runs the breakpoint scan, which reads one entry of each row a
// cycle up to the larger of the two point counts, then fetches the four grid
// corners from the single read port of the grid memory, one a cycle, and
// then makes three rounded divisions in the shared divider, which retires
// two quotient bits a cycle.
// The result is shown for a single cycle with done_o high and cannot be held
// off by the receiver. Reset is asynchronous and active low; it restores the
// point counts to 2 and leaves the table contents undefined.
//
`timescale 1ns / 1ps

module bilinear_table_interpolator_unit import bti_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              command_i,
  input  logic [IDXW-1:0]         entry_index_i,
  input  logic signed [WORDW-1:0] entry_value_i,
  input  logic signed [QW-1:0]    query_x_i,
  input  logic signed [QW-1:0]    query_y_i,
  output logic                    done_o,
  output logic signed [ZW-1:0]    z_value_o,
  output logic                    table_error_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDXW-1:0]     cfg_index_i,
  input  logic [SZW-1:0]          cfg_data_i
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // The size registers take a write in any cycle.
  assign cfg_ready_o = 1'b1;

  bti_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .busy      (busy),
    .done_o    (done_o),
    .cmd_o     (dp_cmd),
    .sts_i     (dp_sts)
  );

  bti_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .sts_o         (dp_sts),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .command_i     (command_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .query_x_i     (query_x_i),
    .query_y_i     (query_y_i),
    .z_value_o     (z_value_o),
    .table_error_o (table_error_o)
  );

  // A result only appears while a query is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> busy)
    else $error("result strobe outside a query");

  // A flagged table always reports a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && table_error_o) |-> (z_value_o == '0))
    else $error("table error with non-zero value");

  // A table write leaves the block free in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i != CMD_QUERY) |=> !busy)
    else $error("table write held the block busy");

  // The strobe lasts one cycle per query.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// Bilinear table interpolator testbench
// Drives table writes, queries and point-count settings into the unit. An
// in-bench predictor works out every query result, and a monitor compares
// each result strobe against the oldest expected result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import bti_pkg::*;

  // Expected content of one result word.
  typedef struct packed {
    logic signed [ZW-1:0] z;
    logic                 err;
  } lookup_result_t;

  // One row of the directed stimulus. Where known is set, the expected result
  // is typed into the row; otherwise the predictor supplies it.
  typedef struct {
    cmd_e                    cmd;
    logic [IDXW-1:0]         idx;
    logic signed [WORDW-1:0] val;
    logic signed [QW-1:0]    qx;
    logic signed [QW-1:0]    qy;
    bit                      known;
    lookup_result_t          res;
  } stim_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [1:0]              command_i = CMD_WR_X;
  logic [IDXW-1:0]         entry_index_i = '0;
  logic signed [WORDW-1:0] entry_value_i = '0;
  logic signed [QW-1:0]    query_x_i = '0;
  logic signed [QW-1:0]    query_y_i = '0;
  logic                    done_o;
  logic signed [ZW-1:0]    z_value_o;
  logic                    table_error_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDXW-1:0]     cfg_index_i = REG_X_POINTS;
  logic [SZW-1:0]          cfg_data_i = '0;

  // The clock runs with a period of 10 ns.
  always #5 clk_i = ~clk_i;

  bilinear_table_interpolator_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .command_i(command_i), .entry_index_i(entry_index_i),
    .entry_value_i(entry_value_i), .query_x_i(query_x_i), .query_y_i(query_y_i),
    .done_o(done_o), .z_value_o(z_value_o), .table_error_o(table_error_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  // Shadow copy of the table and of the two point counts.
  logic signed [WORDW-1:0] x_bp [MAX_X_POINTS];
  logic signed [WORDW-1:0] y_bp [MAX_Y_POINTS];
  logic signed [WORDW-1:0] z_grid [Z_DEPTH];
  int                      x_points = 2;
  int                      y_points = 2;

  lookup_result_t pending_results[$];
  stim_row_t      directed_rows[$];
  int             error_count = 0;
  int             idle_cycles = 0;
  int             sender_idle_pct = 0;

  localparam int WATCHDOG_LIMIT = 20000;

  function automatic longint bp_word(bit on_y, int i);
    return on_y ? longint'(y_bp[i]) : longint'(x_bp[i]);
  endfunction

  function automatic bit row_increasing(bit on_y, int n);
    for (int i = 1; i < n; i++) begin
      if (bp_word(on_y, i - 1) >= bp_word(on_y, i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Lower breakpoint of the pair that brackets q; the end pairs serve for
  // points outside the row, which gives linear extrapolation.
  function automatic int bracket_index(longint q, bit on_y, int n);
    if (q < bp_word(on_y, 0) * 256) return 0;
    if (q >= bp_word(on_y, n - 1) * 256) return n - 2;
    for (int i = 0; i + 1 < n; i++) begin
      if (q >= bp_word(on_y, i) * 256 && q < bp_word(on_y, i + 1) * 256) return i;
    end
    return 0;
  endfunction

  // Division rounded to nearest with ties away from zero, for d > 0.
  function automatic longint div_nearest(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint row_value(int row, int ix, longint dx, longint dxw);
    int     base;
    longint zl, zh;
    base = row * x_points + ix;
    zl   = longint'(z_grid[base]);
    zh   = longint'(z_grid[base + 1]);
    return clamp(zl * 256 + div_nearest(dx * (zh - zl), dxw),
                 -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic lookup_result_t interpolate_point(logic signed [QW-1:0] qx,
                                                       logic signed [QW-1:0] qy);
    lookup_result_t res;
    int             ix, iy;
    longint         dx, dy, dxw, dyw, r1, r2, z;
    res = '0;
    if (x_points < 2 || y_points < 2 || x_points > MAX_X_POINTS ||
        y_points > MAX_Y_POINTS || !row_increasing(1'b0, x_points) ||
        !row_increasing(1'b1, y_points)) begin
      res.err = 1'b1;
      return res;
    end
    ix  = bracket_index(longint'(qx), 1'b0, x_points);
    iy  = bracket_index(longint'(qy), 1'b1, y_points);
    dx  = longint'(qx) - longint'(x_bp[ix]) * 256;
    dxw = longint'(x_bp[ix + 1]) - longint'(x_bp[ix]);
    dy  = longint'(qy) - longint'(y_bp[iy]) * 256;
    dyw = (longint'(y_bp[iy + 1]) - longint'(y_bp[iy])) * 256;
    r1  = row_value(iy, ix, dx, dxw);
    r2  = row_value(iy + 1, ix, dx, dxw);
    z   = clamp(r1 + div_nearest(dy * (r2 - r1), dyw), -64'sd8388608, 64'sd8388607);
    res.z = z[ZW-1:0];
    return res;
  endfunction

  function automatic void store_table_word(cmd_e cmd, logic [IDXW-1:0] idx,
                                           logic signed [WORDW-1:0] val);
    case (cmd)
      CMD_WR_X: begin
        if (idx < MAX_X_POINTS) x_bp[idx] = val;
      end
      CMD_WR_Y: begin
        if (idx < MAX_Y_POINTS) y_bp[idx] = val;
      end
      CMD_WR_Z: begin
        if (idx < Z_DEPTH) z_grid[idx] = val;
      end
      default: ;
    endcase
  endfunction

  // Presents one word and holds it until the unit takes it. The expected
  // result is recorded at the edge of acceptance, in order with the writes.
  task automatic send_word(cmd_e cmd, logic [IDXW-1:0] idx, logic signed [WORDW-1:0] val,
                           logic signed [QW-1:0] qx, logic signed [QW-1:0] qy,
                           bit known = 1'b0, lookup_result_t res = '0);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start         <= 1'b1;
    command_i     <= cmd;
    entry_index_i <= idx;
    entry_value_i <= val;
    query_x_i     <= qx;
    query_y_i     <= qy;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (cmd == CMD_QUERY) begin
      pending_results.push_back(known ? res : interpolate_point(qx, qy));
    end else begin
      store_table_word(cmd, idx, val);
    end
  endtask

  // Waits for every outstanding result, then lets the clock run on, so that the
  // unit is idle before a point count is changed.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDXW-1:0] index, logic [SZW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (index == REG_X_POINTS) x_points = int'(data);
    else if (index == REG_Y_POINTS) y_points = int'(data);
  endtask

  // Loads fresh increasing breakpoint rows and the whole used grid, so that
  // no query can read an entry that was never written.
  task automatic load_table();
    int lvl;
    lvl = -32768 + $urandom_range(0, 2000);
    for (int i = 0; i < x_points; i++) begin
      send_word(CMD_WR_X, IDXW'(i), WORDW'(lvl), '0, '0);
      lvl += $urandom_range(1, 2000);
    end
    lvl = -32768 + $urandom_range(0, 2000);
    for (int i = 0; i < y_points; i++) begin
      send_word(CMD_WR_Y, IDXW'(i), WORDW'(lvl), '0, '0);
      lvl += $urandom_range(1, 2000);
    end
    for (int i = 0; i < x_points * y_points; i++) begin
      send_word(CMD_WR_Z, IDXW'(i), WORDW'($urandom), '0, '0);
    end
  endtask

  // A coordinate near the used breakpoint row, or now and then anywhere.
  function automatic logic signed [QW-1:0] pick_coord(bit on_y, int n);
    longint lo, hi;
    if ($urandom_range(9) < 2) return QW'($urandom);
    lo = bp_word(on_y, 0) * 256 - 2048;
    hi = bp_word(on_y, n - 1) * 256 + 2048;
    return QW'(clamp(lo + longint'($urandom_range(0, 32'(hi - lo))),
                     -64'sd8388608, 64'sd8388607));
  endfunction

  task automatic send_random_word(bit table_ok);
    int          roll;
    int          span;
    logic [IDXW-1:0] idx;
    roll = $urandom_range(99);
    span = x_points * y_points;
    if (roll < 55) begin
      if (table_ok) begin
        send_word(CMD_QUERY, '0, WORDW'($urandom), pick_coord(1'b0, x_points),
                  pick_coord(1'b1, y_points));
      end else begin
        send_word(CMD_QUERY, IDXW'($urandom), WORDW'($urandom), QW'($urandom),
                  QW'($urandom));
      end
    end else if (roll < 92) begin
      // Grid rewrites mostly land inside the used area.
      idx = (table_ok && roll < 85) ? IDXW'($urandom_range(0, span - 1)) : IDXW'($urandom);
      send_word(CMD_WR_Z, idx, WORDW'($urandom), QW'($urandom), QW'($urandom));
    end else begin
      // Breakpoint noise: may break the ordering or fall beyond the row.
      send_word(roll[0] ? CMD_WR_Y : CMD_WR_X, IDXW'($urandom_range(0, 40)),
                WORDW'($urandom), QW'($urandom), QW'($urandom));
    end
  endtask

  // Result checking against the oldest expectation, and the watchdog, which
  // counts cycles in which no word of any channel is accepted.
  always @(posedge clk_i) begin
    lookup_result_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: z_value %0d table_error %0b",
                 z_value_o, table_error_o);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (z_value_o !== want.z) begin
            $error("z_value: expected %0d, actual %0d", want.z, z_value_o);
            error_count++;
          end
          if (table_error_o !== want.err) begin
            $error("table_error: expected %0b, actual %0b", want.err, table_error_o);
            error_count++;
          end
        end
      end
      if (done_o || (start && !busy) || (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("[bilinear_table_interpolator_unit] ERROR");
          $finish;
        end
      end
    end
  end

  function automatic void add_row(cmd_e cmd, int idx, int val, int qx, int qy,
                                  bit known = 1'b0, int ez = 0, bit eerr = 1'b0);
    stim_row_t row;
    row.cmd   = cmd;
    row.idx   = IDXW'(idx);
    row.val   = WORDW'(val);
    row.qx    = QW'(qx);
    row.qy    = QW'(qy);
    row.known = known;
    row.res.z = ZW'(ez);
    row.res.err = eerr;
    directed_rows.push_back(row);
  endfunction

  int phase_x [16] = '{3, 16, 0, 2, 63, 5, 32, 2, 4, 6, 2, 3, 7, 2, 5, 2};
  int phase_y [16] = '{4, 16, 5, 33, 2, 1, 2, 32, 3, 2, 2, 8, 2, 6, 5, 2};
  int idle_plan [4] = '{0, 75, 20, 0};

  initial begin
    bit table_ok;

    // Directed rows on the reset sizes of two points per axis: extreme
    // breakpoints and grid words, corner queries, far extrapolation, rows
    // that are flat or falling, and writes beyond the breakpoint rows.
    add_row(CMD_WR_X, 0, -32768, 0, 0);
    add_row(CMD_WR_X, 1, 32767, 0, 0);
    add_row(CMD_WR_Y, 0, -5, 0, 0);
    add_row(CMD_WR_Y, 1, 5, 0, 0);
    add_row(CMD_WR_Z, 0, -32768, 0, 0);
    add_row(CMD_WR_Z, 1, 32767, 0, 0);
    add_row(CMD_WR_Z, 2, 100, 0, 0);
    add_row(CMD_WR_Z, 3, -100, 0, 0);
    add_row(CMD_QUERY, 0, 0, -32768 * 256, -5 * 256, 1'b1, -8388608, 1'b0);
    add_row(CMD_QUERY, 0, 0, 32767 * 256, -5 * 256, 1'b1, 32767 * 256, 1'b0);
    add_row(CMD_QUERY, 0, 0, -32768 * 256, 5 * 256, 1'b1, 100 * 256, 1'b0);
    add_row(CMD_QUERY, 0, 0, 8388607, 8388607);
    add_row(CMD_QUERY, 0, 0, -8388608, -8388608);
    add_row(CMD_QUERY, 1023, -1, 0, 0);
    add_row(CMD_WR_X, 1, -32768, 0, 0);
    add_row(CMD_QUERY, 0, 0, 0, 0, 1'b1, 0, 1'b1);
    add_row(CMD_WR_X, 0, 100, 0, 0);
    add_row(CMD_QUERY, 0, 0, 0, 0, 1'b1, 0, 1'b1);
    add_row(CMD_WR_X, 0, -32768, 0, 0);
    add_row(CMD_WR_X, 1, 32767, 0, 0);
    add_row(CMD_WR_Y, 1, -5, 0, 0);
    add_row(CMD_QUERY, 0, 0, 0, 0, 1'b1, 0, 1'b1);
    add_row(CMD_WR_Y, 1, 5, 0, 0);
    add_row(CMD_WR_X, 40, 0, 0, 0);
    add_row(CMD_WR_Y, 1023, -32768, 0, 0);
    add_row(CMD_QUERY, 0, 0, 12345, -1000);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].cmd, directed_rows[i].idx, directed_rows[i].val,
                directed_rows[i].qx, directed_rows[i].qy, directed_rows[i].known,
                directed_rows[i].res);
    end

    // The unused register indexes are written once; the unit ignores them.
    drain_results();
    write_register(CFG_IDXW'(2), SZW'($urandom));
    write_register(CFG_IDXW'(3), SZW'($urandom));

    // Each phase holds the sender at rest until every result is in, then
    // sets both point counts, reloads the table where the sizes are usable,
    // and runs a random mix of queries and rewrites.
    for (int p = 0; p < 16; p++) begin
      drain_results();
      sender_idle_pct = idle_plan[p % 4];
      write_register(REG_X_POINTS, SZW'(phase_x[p]));
      write_register(REG_Y_POINTS, SZW'(phase_y[p]));
      table_ok = x_points >= 2 && y_points >= 2 &&
                 x_points <= MAX_X_POINTS && y_points <= MAX_Y_POINTS;
      if (table_ok) load_table();
      for (int n = 0; n < 53; n++) send_random_word(table_ok);
    end

    drain_results();
    repeat (200) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[bilinear_table_interpolator_unit] OK");
    end else begin
      $display("[bilinear_table_interpolator_unit] ERROR");
    end
    $finish;
  end

endmodule
